/* rtl/bms3x3_pkg.sv */
`default_nettype none

package bms3x3_pkg;

    // configuration register file
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MAP_LINES   = 2'd0;
    localparam t_cfg_idx CFG_LINE_LENGTH = 2'd1;

    // stream words, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

endpackage

`default_nettype wire

/* rtl/binary_majority_smoothing_3x3.sv */
`default_nettype none

// 3x3 majority smoother for a binary tile map
// s_axis: one map cell per word in raster order (bit 0: 1 wall, 0 floor);
//   after the map's last cell the host sends line_length+1 filler words
//   (value ignored) to push the tail of the map out
// m_axis: one smoothed cell per word in raster order, tlast on the final
//   cell of the map; a cell is floor when floor cells in its 3x3
//   neighbourhood (off-map neighbours not counted) are at least as many
//   as wall cells
// cfg: write port, index 0 map_lines, index 1 line_length; 0 acts as 1,
//   values above the parameter maximum saturate; a write to either restarts the frame
//   and is only legal while no word is in flight
// throughput: one cell per cycle while m_axis_tready is high; the two line stores
//   share one dual-port ram whose next address is prefetched from the column counter
// latency: a result word appears the cycle after the input word that
//   completes its neighbourhood, i.e. line_length+1 words later in stream
// stall: the result register holds while m_axis_tready is low; s_axis_tready
//   follows m_axis_tready once that register is full
// reset: counters, window and output valid clear, registers return to min(64, max);
//   the line stores need no clearing, stale entries are never counted
module binary_majority_smoothing_3x3 #(
    parameter int MAX_LINE_LENGTH = 1024,
    parameter int MAX_LINES = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // slave stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [bms3x3_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [0] cell_is_wall
    // master stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic      [bms3x3_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [0] out_is_wall
    output logic                                      m_axis_tlast,  // last_cell
    // configuration write
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bms3x3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bms3x3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int LEN_W   = $clog2(MAX_LINE_LENGTH + 1);
    localparam int COL_W   = $clog2(MAX_LINE_LENGTH);
    localparam int LINES_W = $clog2(MAX_LINES + 1);
    localparam int ROW_W   = $clog2(MAX_LINES + 2);
    localparam int RST_LEN   = (MAX_LINE_LENGTH < 64) ? MAX_LINE_LENGTH : 64;
    localparam int RST_LINES = (MAX_LINES < 64) ? MAX_LINES : 64;

    // clamped configuration
    logic [LEN_W-1:0]   r_len;
    logic [LINES_W-1:0] r_lines;

    // raster position of the next input word
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;

    // three columns of three cells, oldest column in the low bits
    logic [8:0] r_win;

    // line store ram: bit 0 upper line, bit 1 middle line
    logic [1:0] ram_q;
    logic [1:0] r_fwd_data;
    logic       r_fwd_hit;
    logic [1:0] store;

    // result register
    logic r_out_valid;
    logic r_out_wall;
    logic r_out_last;

    logic cfg_we;
    logic s_acc;
    logic col_zero;
    logic col_wrap;
    logic emit;
    logic last;
    logic cell_bit;
    logic [ROW_W-1:0] lines_x;
    logic [ROW_W-1:0] row_b;
    logic [2:0] new_col;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [8:0] nbh;
    logic [8:0] nbh_mask;
    logic [3:0] cells;
    logic [3:0] walls;
    logic       smooth_wall;
    logic [LEN_W-1:0]   cfg_len;
    logic [LINES_W-1:0] cfg_lines;

    assign o_cfg_ready   = i_rst_n;
    assign cfg_we        = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // register clamping at write time
    assign cfg_len = (i_cfg_data == '0) ? LEN_W'(1)
                   : (32'(i_cfg_data) > MAX_LINE_LENGTH) ? LEN_W'(MAX_LINE_LENGTH)
                   : LEN_W'(i_cfg_data);
    assign cfg_lines = (i_cfg_data == '0) ? LINES_W'(1)
                     : (32'(i_cfg_data) > MAX_LINES) ? LINES_W'(MAX_LINES)
                     : LINES_W'(i_cfg_data);

    // ram word for the current column, with bypass of last cycle's write
    assign store = r_fwd_hit ? r_fwd_data : ram_q;

    assign lines_x  = ROW_W'(r_lines);
    assign col_zero = (r_col == '0);
    assign col_wrap = (LEN_W'(r_col) + LEN_W'(1)) >= r_len;
    // rows past the map are flushed as floor
    assign cell_bit = (r_row < lines_x) ? s_axis_tdata[0] : 1'b0;
    assign new_col  = {cell_bit, store[1], store[0]};

    assign emit = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && !col_zero);
    assign last = col_zero && (r_row == lines_x + ROW_W'(1));

    // the output cell sits at old window slot 2; at column zero it is the
    // previous line's last cell, whose bottom row is one line further back
    assign row_b = r_row - ROW_W'(col_zero);
    assign row_ok[0] = row_b >= ROW_W'(2);     // top
    assign row_ok[1] = row_b <= lines_x;       // middle
    assign row_ok[2] = row_b < lines_x;        // bottom
    assign col_ok[0] = col_zero ? (r_len >= LEN_W'(2)) : (r_col >= COL_W'(2));
    assign col_ok[1] = 1'b1;
    assign col_ok[2] = !col_zero;

    assign nbh = {new_col, r_win[8:6], r_win[5:3]};

    always_comb begin
        cells = '0;
        walls = '0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                nbh_mask[j*3+i] = col_ok[j] && row_ok[i];
            end
        end
        for (int k = 0; k < 9; k++) begin
            cells = cells + 4'(nbh_mask[k]);
            walls = walls + 4'(nbh_mask[k] && nbh[k]);
        end
    end

    assign smooth_wall = {walls, 1'b0} > {1'b0, cells};

    // next column doubles as the ram prefetch address
    always_comb begin
        if (!i_rst_n || cfg_we) begin
            n_col = '0;
        end else if (s_acc) begin
            n_col = (col_wrap || (emit && last)) ? '0 : r_col + COL_W'(1);
        end else begin
            n_col = r_col;
        end
    end

    bms3x3_ram #(
        .WIDTH (2),
        .DEPTH (MAX_LINE_LENGTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr (r_col),
        .i_wdata ({cell_bit, store[1]}),
        .i_raddr (n_col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_data <= {cell_bit, store[1]};
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= s_acc && (r_col == n_col);
        end
    end

    // configuration and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(RST_LEN);
            r_lines <= LINES_W'(RST_LINES);
            r_row   <= '0;
            r_col   <= '0;
            r_win   <= '0;
        end else if (cfg_we) begin
            if (i_cfg_index == bms3x3_pkg::CFG_MAP_LINES) begin
                r_lines <= cfg_lines;
            end
            if (i_cfg_index == bms3x3_pkg::CFG_LINE_LENGTH) begin
                r_len <= cfg_len;
            end
            if ((i_cfg_index == bms3x3_pkg::CFG_MAP_LINES) ||
                (i_cfg_index == bms3x3_pkg::CFG_LINE_LENGTH)) begin
                r_row <= '0;
                r_col <= '0;
                r_win <= '0;
            end
        end else if (s_acc) begin
            r_col <= n_col;
            if (emit && last) begin
                // frame done, start over
                r_row <= '0;
                r_win <= '0;
            end else begin
                r_win <= {new_col, r_win[8:3]};
                if (col_wrap) begin
                    r_row <= r_row + ROW_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s_acc && emit) begin
            r_out_wall <= smooth_wall;
            r_out_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(bms3x3_pkg::M_TDATA_W-1)'(0), r_out_wall};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/bms3x3_ram.sv */
`default_nettype none

module bms3x3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old word on an address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/bms3x3_chk.sv */
`default_nettype none

module bms3x3_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [bms3x3_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // a fresh result word needs an accepted input word in the previous cycle
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |->
            $past(s_axis_tvalid && s_axis_tready))
        else $error("result word without input word");

    // empty result register never blocks the input
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // result valid clears out of reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind binary_majority_smoothing_3x3 bms3x3_chk u_bms3x3_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
